// ===== src/sph_pkg.sv =====
// Shared types and constants of the symbol and pair histogram.
// Field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sph_pkg;

    localparam int SYM_W      = 3;
    localparam int IDX_W      = 3;
    localparam int CNT_OUT_W  = 32;
    localparam int TOT_W      = 38;
    localparam int FACES_W    = 3;
    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_FACES_DEF  = 7;
    localparam int COUNT_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FACES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_IVL = 2'd2;

    localparam logic [FACES_W-1:0] FACES_RST      = 3'd6;
    localparam logic [LEN_W-1:0]   BLOCK_LEN_RST  = 16'd1024;
    localparam logic [LEN_W-1:0]   REPORT_IVL_RST = 16'd1;

    localparam logic KIND_SINGLE = 1'b0;
    localparam logic KIND_PAIR   = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SUM,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/sph_if.sv =====
// Stream channels of the histogram: symbol words in, count words out.
// Depends on sph_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sph_sym_if;
    logic                       valid;
    logic                       ready;
    logic [sph_pkg::SYM_W-1:0]  symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface sph_res_if;
    logic                          valid;
    logic                          ready;
    logic                          table_kind;
    logic [sph_pkg::IDX_W-1:0]     row_index;
    logic [sph_pkg::IDX_W-1:0]     col_index;
    logic [sph_pkg::CNT_OUT_W-1:0] count_value;
    logic [sph_pkg::TOT_W-1:0]     table_total;
    logic                          last_of_report;

    modport source (output valid, output table_kind, output row_index, output col_index,
                    output count_value, output table_total, output last_of_report,
                    input ready);
    modport sink   (input valid, input table_kind, input row_index, input col_index,
                    input count_value, input table_total, input last_of_report,
                    output ready);
endinterface

`default_nettype wire

// ===== src/symbol_and_pair_histogram.sv =====
// Symbol and pair histogram top level: update pipeline and report sequencer.
// Depends on sph_pkg, sph_if (sph_sym_if, sph_res_if) and sph_store.
//
// Usage:
//   i_sym carries one symbol word per handshake (valid and ready high at a
//   rising edge). Symbols 1..faces bump the single table; even/odd pairs in a
//   block bump the pair table. Out-of-range symbols are not counted.
//   o_res carries report words: faces single counts, then faces*faces pair
//   counts in row-major order, each with its table total; last_of_report
//   marks the final pair word.
//   Throughput: one symbol per cycle outside a report, kept up through the
//   read-modify-write of the two count RAMs (read, then write in the next
//   cycle, bypass on overlap). At the end of a reporting block input stops:
//   the final write completes, both tables are summed, then faces + faces*faces
//   words at one per cycle while the receiver takes them. A stalled receiver
//   holds the output register and the sequencer; symbols resume once the
//   last word is loaded, even while it still waits.
//   Reset (synchronous, active low) restores the register defaults and
//   clears the per-entry valid bits, so all counts read zero at once.
//   Configuration via i_cfg_we / i_cfg_idx / i_cfg_data while idle.
`timescale 1ns / 1ps
`default_nettype none

module symbol_and_pair_histogram #(
    parameter int MAX_FACES  = sph_pkg::MAX_FACES_DEF,
    parameter int COUNT_BITS = sph_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sph_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sph_sym_if.sink                             i_sym,
    sph_res_if.source                           o_res
);

    localparam int SGL_AW  = $clog2(MAX_FACES);
    localparam int PAIR_AW = $clog2(MAX_FACES * MAX_FACES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [PAIR_AW-1:0] f_pair_addr(
        input logic [sph_pkg::IDX_W-1:0] row,
        input logic [sph_pkg::IDX_W-1:0] col
    );
        return PAIR_AW'(row) * PAIR_AW'(MAX_FACES) + PAIR_AW'(col);
    endfunction

    // configuration
    logic [sph_pkg::FACES_W-1:0] r_faces;
    logic [sph_pkg::LEN_W-1:0]   r_block_len;
    logic [sph_pkg::LEN_W-1:0]   r_report_ivl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faces      <= sph_pkg::FACES_RST;
            r_block_len  <= sph_pkg::BLOCK_LEN_RST;
            r_report_ivl <= sph_pkg::REPORT_IVL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sph_pkg::CFG_FACES:      r_faces      <= i_cfg_data[sph_pkg::FACES_W-1:0];
                sph_pkg::CFG_BLOCK_LEN:  r_block_len  <= i_cfg_data[sph_pkg::LEN_W-1:0];
                sph_pkg::CFG_REPORT_IVL: r_report_ivl <= i_cfg_data[sph_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [sph_pkg::FACES_W-1:0] faces;
    logic [sph_pkg::IDX_W-1:0]   faces_m1;
    logic [sph_pkg::LEN_W-1:0]   len_eff;
    logic [sph_pkg::LEN_W-1:0]   ivl_eff;

    always_comb begin
        if (r_faces < 3'd2) begin
            faces = 3'd2;
        end else if (r_faces > 3'(MAX_FACES)) begin
            faces = 3'(MAX_FACES);
        end else begin
            faces = r_faces;
        end
    end
    assign faces_m1 = faces - 3'd1;
    assign len_eff  = (r_block_len == '0) ? 16'd1 : r_block_len;
    assign ivl_eff  = (r_report_ivl == '0) ? 16'd1 : r_report_ivl;

    // sequencer state
    sph_pkg::t_state           r_state, n_state;
    logic [sph_pkg::IDX_W-1:0] r_row, n_row;
    logic [sph_pkg::IDX_W-1:0] r_col, n_col;
    logic                      r_kind, n_kind;

    // update stage 1
    logic              r_s1_valid;
    logic              r_s1_rep;
    logic              r_s1_sgl_en;
    logic              r_s1_pair_en;
    logic [SGL_AW-1:0]  r_s1_sgl_addr;
    logic [PAIR_AW-1:0] r_s1_pair_addr;

    // stream state
    logic [sph_pkg::LEN_W-1:0] r_pos;
    logic [sph_pkg::SYM_W-1:0] r_held;
    logic                      r_held_vld;
    logic [sph_pkg::LEN_W-1:0] r_btr;

    // output register
    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [sph_pkg::IDX_W-1:0]     r_out_row;
    logic [sph_pkg::IDX_W-1:0]     r_out_col;
    logic [sph_pkg::CNT_OUT_W-1:0] r_out_count;
    logic [sph_pkg::TOT_W-1:0]     r_out_total;
    logic                          r_out_last;

    logic [sph_pkg::TOT_W-1:0] r_sgl_total;
    logic [sph_pkg::TOT_W-1:0] r_pair_total;

    // stage 0: decode the accepted symbol
    logic                      accept;
    logic [sph_pkg::SYM_W-1:0] sym;
    logic [sph_pkg::SYM_W-1:0] sym_m1;
    logic                      sym_ok;
    logic                      pair_ok;
    logic [sph_pkg::LEN_W-1:0] pos_inc;
    logic                      blk_end;
    logic                      rep_now;
    logic [SGL_AW-1:0]         upd_sgl_addr;
    logic [PAIR_AW-1:0]        upd_pair_addr;

    assign i_sym.ready = (r_state == sph_pkg::ST_RUN) && !(r_s1_valid && r_s1_rep);
    assign accept      = i_sym.valid && i_sym.ready;
    assign sym         = i_sym.symbol;
    assign sym_m1      = sym - 3'd1;
    assign sym_ok      = (sym >= 3'd1) && (sym <= faces);
    assign pair_ok     = sym_ok && r_pos[0] && r_held_vld && (r_held < faces);
    assign pos_inc     = r_pos + 16'd1;
    assign blk_end     = (pos_inc >= len_eff) || (pos_inc == '0);
    assign rep_now     = blk_end && (r_btr <= 16'd1);

    assign upd_sgl_addr  = sym_ok ? SGL_AW'(sym_m1) : '0;
    assign upd_pair_addr = pair_ok ? f_pair_addr(r_held, sym_m1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_held       <= '0;
            r_held_vld   <= 1'b0;
            r_btr        <= sph_pkg::REPORT_IVL_RST;
            r_s1_valid   <= 1'b0;
            r_s1_rep     <= 1'b0;
            r_s1_sgl_en  <= 1'b0;
            r_s1_pair_en <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_s1_rep     <= rep_now;
                r_s1_sgl_en  <= sym_ok;
                r_s1_pair_en <= pair_ok;
                if (!r_pos[0]) begin
                    r_held     <= sym_ok ? sym_m1 : '0;
                    r_held_vld <= sym_ok && !blk_end;
                end else begin
                    r_held_vld <= 1'b0;
                end
                if (blk_end) begin
                    r_pos <= '0;
                    r_btr <= (r_btr <= 16'd1) ? ivl_eff : r_btr - 16'd1;
                end else begin
                    r_pos <= pos_inc;
                end
            end
        end
        if (accept) begin
            r_s1_sgl_addr  <= upd_sgl_addr;
            r_s1_pair_addr <= upd_pair_addr;
        end
    end

    // count stores
    logic [SGL_AW-1:0]     sgl_rd_addr;
    logic [PAIR_AW-1:0]    pair_rd_addr;
    logic [COUNT_BITS-1:0] sgl_rd;
    logic [COUNT_BITS-1:0] pair_rd;
    logic                  sgl_we;
    logic                  pair_we;
    logic [COUNT_BITS-1:0] sgl_wdata;
    logic [COUNT_BITS-1:0] pair_wdata;

    assign sgl_we     = r_s1_valid && r_s1_sgl_en;
    assign pair_we    = r_s1_valid && r_s1_pair_en;
    assign sgl_wdata  = (sgl_rd == COUNT_MAX) ? sgl_rd : sgl_rd + 1'b1;
    assign pair_wdata = (pair_rd == COUNT_MAX) ? pair_rd : pair_rd + 1'b1;

    always_comb begin
        case (n_state)
            sph_pkg::ST_RUN: begin
                sgl_rd_addr  = upd_sgl_addr;
                pair_rd_addr = upd_pair_addr;
            end
            sph_pkg::ST_SUM: begin
                sgl_rd_addr  = SGL_AW'(n_col);
                pair_rd_addr = f_pair_addr(n_row, n_col);
            end
            default: begin
                sgl_rd_addr  = SGL_AW'(n_row);
                pair_rd_addr = f_pair_addr(n_row, n_col);
            end
        endcase
    end

    sph_store #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_FACES)
    ) u_sgl_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (sgl_rd_addr),
        .i_we      (sgl_we),
        .i_wr_addr (r_s1_sgl_addr),
        .i_wr_data (sgl_wdata),
        .o_rd_data (sgl_rd)
    );

    sph_store #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_FACES * MAX_FACES)
    ) u_pair_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (pair_rd_addr),
        .i_we      (pair_we),
        .i_wr_addr (r_s1_pair_addr),
        .i_wr_data (pair_wdata),
        .o_rd_data (pair_rd)
    );

    // report sequencer
    logic out_load;
    logic row_last;
    logic col_last;

    assign out_load = (r_state == sph_pkg::ST_EMIT) && (!r_out_valid || o_res.ready);
    assign row_last = (r_row == faces_m1);
    assign col_last = (r_col == faces_m1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            sph_pkg::ST_RUN: begin
                if (r_s1_valid && r_s1_rep) begin
                    n_state = sph_pkg::ST_SUM;
                end
            end
            sph_pkg::ST_SUM: begin
                if (row_last && col_last) begin
                    n_state = sph_pkg::ST_EMIT;
                end
            end
            sph_pkg::ST_EMIT: begin
                if (out_load && (r_kind == sph_pkg::KIND_PAIR) && row_last && col_last) begin
                    n_state = sph_pkg::ST_RUN;
                end
            end
            default: n_state = sph_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_kind = r_kind;
        case (r_state)
            sph_pkg::ST_RUN: begin
                n_row  = '0;
                n_col  = '0;
                n_kind = sph_pkg::KIND_SINGLE;
            end
            sph_pkg::ST_SUM: begin
                if (col_last) begin
                    n_col = '0;
                    n_row = row_last ? '0 : r_row + 3'd1;
                end else begin
                    n_col = r_col + 3'd1;
                end
            end
            sph_pkg::ST_EMIT: begin
                if (out_load) begin
                    if (r_kind == sph_pkg::KIND_SINGLE) begin
                        if (row_last) begin
                            n_row  = '0;
                            n_kind = sph_pkg::KIND_PAIR;
                        end else begin
                            n_row = r_row + 3'd1;
                        end
                    end else if (col_last) begin
                        n_col = '0;
                        n_row = row_last ? '0 : r_row + 3'd1;
                    end else begin
                        n_col = r_col + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sph_pkg::ST_RUN;
            r_row       <= '0;
            r_col       <= '0;
            r_kind      <= sph_pkg::KIND_SINGLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_kind  <= n_kind;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // totals and output payload
    always_ff @(posedge i_clk) begin
        if (r_state == sph_pkg::ST_RUN) begin
            r_sgl_total  <= '0;
            r_pair_total <= '0;
        end else if (r_state == sph_pkg::ST_SUM) begin
            r_pair_total <= r_pair_total + sph_pkg::TOT_W'(pair_rd);
            if (r_row == '0) begin
                r_sgl_total <= r_sgl_total + sph_pkg::TOT_W'(sgl_rd);
            end
        end
        if (out_load) begin
            r_out_kind  <= r_kind;
            r_out_row   <= r_row;
            r_out_col   <= (r_kind == sph_pkg::KIND_PAIR) ? r_col : '0;
            r_out_count <= (r_kind == sph_pkg::KIND_PAIR) ? sph_pkg::CNT_OUT_W'(pair_rd)
                                                          : sph_pkg::CNT_OUT_W'(sgl_rd);
            r_out_total <= (r_kind == sph_pkg::KIND_PAIR) ? r_pair_total : r_sgl_total;
            r_out_last  <= (r_kind == sph_pkg::KIND_PAIR) && row_last && col_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.table_kind     = r_out_kind;
    assign o_res.row_index      = r_out_row;
    assign o_res.col_index      = r_out_col;
    assign o_res.count_value    = r_out_count;
    assign o_res.table_total    = r_out_total;
    assign o_res.last_of_report = r_out_last;

    // checks
    a_no_update_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sph_pkg::ST_RUN) |-> !r_s1_valid)
        else $error("update pending during report");

    a_report_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sph_pkg::ST_RUN && r_s1_valid && r_s1_rep) |=> (r_state == sph_pkg::ST_SUM))
        else $error("report did not start after block end");

    a_last_is_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last_of_report) |-> (o_res.table_kind == sph_pkg::KIND_PAIR))
        else $error("last word is not a pair count");

    a_emit_only_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && $past(i_rst_n) && $past(r_state == sph_pkg::ST_RUN)
            && (r_state == sph_pkg::ST_RUN)) |=> !r_out_valid)
        else $error("output word outside a report");

endmodule

`default_nettype wire

// ===== src/sph_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/sph_store.sv =====
// Count store: RAM plus per-entry valid bits and a same-edge write bypass.
// Entries never written read as zero. Depends on sph_ram.
`timescale 1ns / 1ps
`default_nettype none

module sph_store #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;
    logic             r_byp_hit;
    logic [WIDTH-1:0] r_byp_data;
    logic [WIDTH-1:0] ram_data;
    logic             same_addr;

    assign same_addr = i_we && (i_wr_addr == i_rd_addr);

    sph_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_we),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld  <= r_vld[i_rd_addr] | same_addr;
            r_byp_hit <= same_addr;
        end
        r_byp_data <= i_wr_data;
    end

    always_comb begin
        if (r_byp_hit) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_vld) begin
            o_rd_data = ram_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire
